@@ src/signed_binary_to_decimal_ascii_core_macros.svh @@
// Assertion macros shared by the decimal text converter modules.
`ifndef SIGNED_BINARY_TO_DECIMAL_ASCII_CORE_MACROS_SVH
`define SIGNED_BINARY_TO_DECIMAL_ASCII_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SBDA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SBDA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/sbda_pkg.sv @@
// Shared constants and types of the signed binary to decimal ASCII converter.
package sbda_pkg;

    // Input word and BCD register geometry
    localparam int BIN_W     = 32;
    localparam int DIGIT_W   = 4;
    localparam int HW_DIGITS = 10;
    localparam int BCD_W     = HW_DIGITS * DIGIT_W;
    localparam int STEP_W    = $clog2(BIN_W);
    localparam int REM_W     = $clog2(HW_DIGITS + 1);

    // Default digit buffer capacity
    localparam int MAX_DIGITS_DEF = 10;

    // Character codes
    localparam int            CHAR_W     = 7;
    localparam logic [6:0]    CHAR_ZERO  = 7'd48;
    localparam logic [6:0]    CHAR_MINUS = 7'd45;

    // Converter to emitter handoff
    typedef struct packed {
        logic done;
        logic negative;
    } dab_res_t;

endpackage

@@ src/sbda_dabble.sv @@
// Bit-serial shift-and-add-3 binary to BCD converter.
`include "signed_binary_to_decimal_ascii_core_macros.svh"
module sbda_dabble (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        negative,
    input  logic [sbda_pkg::BIN_W-1:0]  magnitude,
    output logic                        busy,
    output sbda_pkg::dab_res_t          res,
    output logic [sbda_pkg::BCD_W-1:0]  bcd
);
    import sbda_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic                neg_reg, neg_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [BIN_W-1:0]    bin_reg, bin_next;
    logic [BCD_W-1:0]    bcd_reg, bcd_next;
    logic [BCD_W-1:0]    bcd_adj;

    // Add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < HW_DIGITS; i++)
        begin
            if (bcd_reg[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5))
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
            else
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W];
        end
    end

    // Load, then shift one binary bit into the BCD register per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        step_next = step_reg;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        if (start)
        begin
            busy_next = 1'b1;
            neg_next  = negative;
            step_next = STEP_W'(BIN_W - 1);
            bin_next  = magnitude;
            bcd_next  = '0;
        end
        else if (busy_reg)
        begin
            bcd_next  = {bcd_adj[BCD_W-2:0], bin_reg[BIN_W-1]};
            bin_next  = {bin_reg[BIN_W-2:0], 1'b0};
            step_next = step_reg - STEP_W'(1);
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            neg_reg  <= 1'b0;
            step_reg <= '0;
            bin_reg  <= '0;
            bcd_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            neg_reg  <= neg_next;
            step_reg <= step_next;
            bin_reg  <= bin_next;
            bcd_reg  <= bcd_next;
        end
    end

    assign busy         = busy_reg;
    assign res.done     = done_reg;
    assign res.negative = neg_reg;
    assign bcd          = bcd_reg;

    `SBDA_ASSERT_NOW(a_no_restart, start, !busy_reg && !done_reg, "conversion restarted while busy")

endmodule

@@ src/sbda_emit.sv @@
// Leading-zero skip and character emitter with registered output.
`include "signed_binary_to_decimal_ascii_core_macros.svh"
module sbda_emit #(
    parameter int MAX_DIGITS = sbda_pkg::MAX_DIGITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sbda_pkg::dab_res_t           res,
    input  logic [sbda_pkg::BCD_W-1:0]   bcd,
    output logic                         busy,
    output logic [sbda_pkg::CHAR_W-1:0]  char_code,
    output logic                         last_char,
    output logic                         out_valid,
    input  logic                         out_ready
);
    import sbda_pkg::*;

    localparam int LIMIT = (MAX_DIGITS < HW_DIGITS) ? MAX_DIGITS : HW_DIGITS;

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_SIGN, ST_EMIT} state_t;

    state_t              state_reg, state_next;
    logic [BCD_W-1:0]    digits_reg, digits_next;
    logic [REM_W-1:0]    remain_reg, remain_next;
    logic                neg_reg, neg_next;
    logic                seen_reg, seen_next;
    logic                out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]   char_reg, char_next;
    logic                last_reg, last_next;

    logic                slot_free;
    logic                run_end;
    logic [DIGIT_W-1:0]  top_digit;
    logic [BCD_W-1:0]    digits_shl;

    assign slot_free  = !out_valid_reg || out_ready;
    assign run_end    = (state_reg == ST_EMIT) && slot_free && (remain_reg == REM_W'(1));
    assign top_digit  = digits_reg[BCD_W-1 -: DIGIT_W];
    assign digits_shl = {digits_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};

    // Sequencer: drop digits above the buffer, then leading zeros only when
    // nothing nonzero was dropped, then a '-' for a negative value, then emit
    always_comb
    begin
        state_next     = state_reg;
        digits_next    = digits_reg;
        remain_next    = remain_reg;
        neg_next       = neg_reg;
        seen_next      = seen_reg;
        out_valid_next = out_valid_reg && !out_ready;
        char_next      = char_reg;
        last_next      = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (res.done)
                begin
                    digits_next = bcd;
                    remain_next = REM_W'(HW_DIGITS);
                    neg_next    = res.negative;
                    seen_next   = 1'b0;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (remain_reg > REM_W'(LIMIT))
                begin
                    // digit above the buffer; a nonzero one keeps the zeros below it
                    digits_next = digits_shl;
                    remain_next = remain_reg - REM_W'(1);
                    if (top_digit != '0)
                        seen_next = 1'b1;
                end
                else if (!seen_reg && (top_digit == '0) && (remain_reg > REM_W'(1)))
                begin
                    digits_next = digits_shl;
                    remain_next = remain_reg - REM_W'(1);
                end
                else
                    state_next = ST_SIGN;
            end
            ST_SIGN:
            begin
                if (!neg_reg)
                    state_next = ST_EMIT;
                else if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = CHAR_MINUS;
                    last_next      = 1'b0;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = CHAR_ZERO + CHAR_W'(top_digit);
                    last_next      = (remain_reg == REM_W'(1));
                    digits_next    = digits_shl;
                    remain_next    = remain_reg - REM_W'(1);
                    if (remain_reg == REM_W'(1))
                        state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            digits_reg    <= '0;
            remain_reg    <= '0;
            neg_reg       <= 1'b0;
            seen_reg      <= 1'b0;
            char_reg      <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            digits_reg    <= digits_next;
            remain_reg    <= remain_next;
            neg_reg       <= neg_next;
            seen_reg      <= seen_next;
            char_reg      <= char_next;
            last_reg      <= last_next;
        end
    end

    assign busy      = (state_reg != ST_IDLE);
    assign char_code = char_reg;
    assign last_char = last_reg;
    assign out_valid = out_valid_reg;

    `SBDA_ASSERT_NOW(a_emit_has_digit, state_reg == ST_EMIT, remain_reg != '0, "emit with no digit left")
    `SBDA_ASSERT_NOW(a_start_idle, res.done, state_reg == ST_IDLE, "conversion result arrived while emitting")
    `SBDA_ASSERT_NEXT(a_last_ends_run, run_end, (state_reg == ST_IDLE) && out_valid_reg && last_reg, "final character did not end the run")

endmodule

@@ src/signed_binary_to_decimal_ascii_core.sv @@
// Signed 32-bit integer to decimal ASCII text converter, top level.
//
// Each accepted signed_value yields its decimal text as a run of transactions on the output,
// most significant character first: '-' for a negative value, then the digits of the
// magnitude with no leading zeros ('0' alone for zero; the most negative value gives
// "-2147483648"). last_char marks the final character of each run. Only the MAX_DIGITS
// least significant digits are kept when the magnitude has more, and zeros at the head of
// the kept part are then sent. From one accepted input to the next come the accept cycle,
// the 32 steps of the bit-serial shift-and-add-3 converter, a handoff, the scan that drops
// unused high digits and leading zeros, the sign state that is passed for every value, and
// the digits sent one per cycle while out_ready is high; a character that waits on out_ready
// holds up the run. in_ready is high only while no item is in flight; the last character
// may still wait in the output register when the next item is taken.
`include "signed_binary_to_decimal_ascii_core_macros.svh"
module signed_binary_to_decimal_ascii_core #(
    parameter int MAX_DIGITS = sbda_pkg::MAX_DIGITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [sbda_pkg::BIN_W-1:0] signed_value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [sbda_pkg::CHAR_W-1:0]  char_code,
    output logic                         last_char
);
    import sbda_pkg::*;

    logic               accept;
    logic               negative;
    logic [BIN_W-1:0]   magnitude;
    logic               dab_busy;
    logic               emit_busy;
    dab_res_t           dab_res;
    logic [BCD_W-1:0]   bcd;

    // Take a new item only when nothing is in flight
    assign in_ready = !dab_busy && !dab_res.done && !emit_busy;
    assign accept   = in_valid && in_ready;

    // Magnitude as unsigned; the most negative value maps to 2^31
    assign negative  = signed_value[BIN_W-1];
    assign magnitude = negative ? (~BIN_W'(signed_value) + BIN_W'(1)) : BIN_W'(signed_value);

    sbda_dabble u_dabble (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .negative  (negative),
        .magnitude (magnitude),
        .busy      (dab_busy),
        .res       (dab_res),
        .bcd       (bcd)
    );

    sbda_emit #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (dab_res),
        .bcd       (bcd),
        .busy      (emit_busy),
        .char_code (char_code),
        .last_char (last_char),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

endmodule

@@ test/signed_binary_to_decimal_ascii_core_checker.sv @@
// Scoreboard for the decimal text converter: predicts each character and checks the output.
`timescale 1ns / 100ps
module signed_binary_to_decimal_ascii_core_checker #(
    parameter int MAX_DIGITS = sbda_pkg::MAX_DIGITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic signed [sbda_pkg::BIN_W-1:0] signed_value,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [sbda_pkg::CHAR_W-1:0]       char_code,
    input  logic                              last_char,
    output int                                fail_count,
    output int                                pending
);
    import sbda_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } text_char_t;

    // Characters still owed by the block, oldest first
    text_char_t expected_text[$];
    int         mismatches = 0;
    int         owed = 0;

    assign fail_count = mismatches;
    assign pending    = owed;

    task automatic report_mismatch(input string what);
        // keep the log short when the block is badly broken
        if (mismatches < 50)
            $display("%0t ns: MISMATCH %s", $time, what);
        mismatches++;
    endtask

    // Decimal text of one signed word: sign, then kept digits most significant first
    function automatic void render_decimal(input logic signed [BIN_W-1:0] value);
        logic [BIN_W-1:0]  mag;
        logic              negative;
        logic [CHAR_W-1:0] digit_chars [HW_DIGITS];
        int                keep;
        int                n;
        text_char_t        c;
        negative = value[BIN_W-1];
        mag      = negative ? (32'd0 - value) : value;
        keep     = (MAX_DIGITS < HW_DIGITS) ? MAX_DIGITS : HW_DIGITS;
        n        = 0;
        if (mag == 0)
        begin
            c.code = CHAR_ZERO;
            c.last = 1'b1;
            expected_text.push_back(c);
            return;
        end
        // peel off least significant digits until none left or buffer full
        while (mag != 0 && n < keep)
        begin
            digit_chars[n] = CHAR_ZERO + CHAR_W'(mag % 10);
            mag            = mag / 10;
            n++;
        end
        if (negative)
        begin
            c.code = CHAR_MINUS;
            c.last = (n == 0);
            expected_text.push_back(c);
        end
        for (int i = n - 1; i >= 0; i--)
        begin
            c.code = digit_chars[i];
            c.last = (i == 0);
            expected_text.push_back(c);
        end
    endfunction

    // Compare output transactions first, then queue the characters of a new input
    always @(posedge clk)
    begin
        text_char_t want;
        if (!rst_n)
        begin
            expected_text.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_text.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected char %0d last %0b",
                                              char_code, last_char));
                end
                else
                begin
                    want = expected_text.pop_front();
                    if (char_code !== want.code || last_char !== want.last)
                        report_mismatch($sformatf("char %0d last %0b, expected %0d last %0b",
                                                  char_code, last_char, want.code, want.last));
                end
            end
            if (in_valid && in_ready)
                render_decimal(signed_value);
        end
        owed = expected_text.size();
    end

endmodule

@@ test/signed_binary_to_decimal_ascii_core_tb.sv @@
// Top of the decimal text converter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module signed_binary_to_decimal_ascii_core_tb;
    import sbda_pkg::*;

    localparam int MAX_DIGITS   = MAX_DIGITS_DEF;
    localparam int PHASE_ITEMS  = 150;
    localparam int DRAIN_CYCLES = 60;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic signed [BIN_W-1:0]  signed_value = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [CHAR_W-1:0]        char_code;
    logic                     last_char;
    int                       fail_count;
    int                       pending;

    // Percent of cycles each side holds off
    int                       send_idle_pct = 0;
    int                       recv_idle_pct = 0;

    signed_binary_to_decimal_ascii_core #(
        .MAX_DIGITS(MAX_DIGITS)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .signed_value(signed_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .char_code   (char_code),
        .last_char   (last_char)
    );

    signed_binary_to_decimal_ascii_core_checker #(
        .MAX_DIGITS(MAX_DIGITS)
    ) scoreboard (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .signed_value(signed_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .char_code   (char_code),
        .last_char   (last_char),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    always #5 clk = ~clk;

    // Receiver backpressure
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Run limit
    initial
    begin
        #10ms;
        $display("Some tests failed");
        $finish;
    end

    // Offer one word and hold it until the transaction completes; entered and left at negedge
    task automatic send_value(input logic signed [BIN_W-1:0] value);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        signed_value <= value;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // Random word with a spread of digit counts, signs and decade edges
    function automatic logic signed [BIN_W-1:0] pick_value();
        logic [BIN_W-1:0] raw;
        logic [BIN_W-1:0] lo;
        logic [BIN_W-1:0] hi;
        int               digits;
        digits = $urandom_range(1, HW_DIGITS);
        lo     = 1;
        for (int k = 1; k < digits; k++)
            lo = lo * 10;
        hi = (digits == HW_DIGITS) ? 32'h7FFF_FFFF : lo * 10 - 1;
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: raw = $urandom_range(0, 99);
            2: raw = $urandom_range(hi, lo);
            default: raw = lo - $urandom_range(0, 1);
        endcase
        if ($urandom_range(0, 1))
            raw = 32'd0 - raw;
        return raw;
    endfunction

    // Stimulus
    initial
    begin
        logic signed [BIN_W-1:0] corner_values [$];
        corner_values = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd100,
                          -32'sd5, 32'sd12345, 32'sd999999999, -32'sd999999999,
                          32'sd1000000000, -32'sd1000000000, 32'sh7FFF_FFFF,
                          32'sh8000_0000, 32'sh8000_0001, 32'sh5555_5555, 32'shAAAA_AAAA};

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed corners, no idling
        foreach (corner_values[i])
            send_value(corner_values[i]);

        // slow receiver, then slow sender, then full rate
        send_idle_pct = 21;
        recv_idle_pct = 87;
        repeat (PHASE_ITEMS) send_value(pick_value());
        send_idle_pct = 87;
        recv_idle_pct = 21;
        repeat (PHASE_ITEMS) send_value(pick_value());
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (PHASE_ITEMS) send_value(pick_value());
        in_valid <= 1'b0;

        // drain, then let any stray characters show up
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
